FILE: rtl/core/lmc_pkg.sv
// Shared types and constants of the least laxity first task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package lmc_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int MAX_STEPS_DEF = 64;

	localparam int IDXW  = 6;   // task index, up to 64 tasks
	localparam int CNTW  = 7;   // task count, 0..64
	localparam int RUNW  = 11;  // step count, 0..1024
	localparam int SLW   = 18;  // slack and deadline
	localparam int KW    = 20;  // one-tick-ahead deadline, laxity and demand index
	localparam int PRODW = 30;  // remaining steps times slack
	localparam int RW    = KW + IDXW;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 56;

	localparam logic signed [SLW-1:0] SLACK_MAX = 18'sh1FFFF;
	localparam logic signed [SLW-1:0] SLACK_MIN = 18'sh20000;

	typedef enum logic [1:0] {
		OP_TASK    = 2'd0,
		OP_PROFILE = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_RELEASE,
		CMD_PREP,
		CMD_UPDATE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDXW-1:0]  idx;
		logic             sel_v;
		logic [RUNW-1:0]  needed;
		logic [15:0]      deadline;
		logic [15:0]      release_tick;
		logic [15:0]      tick;
		logic [CNTW-1:0]  n;
	} cell_cmd_t;

	typedef struct packed {
		logic [CNTW-1:0]          fin;
		logic [CNTW-1:0]          act_cnt;
		logic                     pv;
		logic [IDXW-1:0]          pidx;
		logic signed [PRODW-1:0]  pval;
		logic [RUNW-1:0]          prun;
		logic                     sv;
		logic [IDXW-1:0]          sidx;
		logic signed [SLW-1:0]    sval;
		logic [RUNW-1:0]          srun;
		logic                     fail;
		logic signed [KW-1:0]     dmax;
	} scan_pkt_t;

	typedef struct packed {
		logic           v;
		logic [KW-1:0]  k;
		logic [RW-1:0]  r;
	} dem_pkt_t;

endpackage
`default_nettype wire

FILE: rtl/core/lmc_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/lmc_cell.sv
// One task cell: task state, scan stage and demand stage of the chain.
`timescale 1ns / 1ps
`default_nettype none
module lmc_cell #(
	parameter int IDX       = 0,
	parameter int MAX_STEPS = lmc_pkg::MAX_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lmc_pkg::cell_cmd_t cmd,
	input  wire lmc_pkg::scan_pkt_t scan_i,
	output lmc_pkg::scan_pkt_t      scan_o,
	input  wire lmc_pkg::dem_pkt_t  dem_i,
	output lmc_pkg::dem_pkt_t       dem_o,
	output logic                    miss
);

	localparam int CW  = $clog2(MAX_STEPS + 1);
	localparam int SLW = lmc_pkg::SLW;
	localparam int KW  = lmc_pkg::KW;
	localparam int RW  = lmc_pkg::RW;

	logic signed [SLW-1:0] dl_q;
	logic [CW-1:0]         need_q;
	logic [15:0]           rel_q;
	logic [CW-1:0]         run_q;
	logic signed [SLW-1:0] slack_q;
	logic                  act_q;
	logic                  done_q;
	logic signed [KW-1:0]  sd_q;
	logic signed [KW-1:0]  sl_q;
	logic [CW-1:0]         rem_q;

	logic                  in_use;
	logic                  hit;
	logic signed [SLW-1:0] dl_dec;
	logic [CW-1:0]         run_inc;
	logic signed [SLW-1:0] lax_rel;
	logic signed [SLW-1:0] lax_hit;
	logic signed [SLW-1:0] lax_oth;
	logic                  rel_go;
	logic                  upd_go;
	logic                  fin_go;
	logic signed [KW-1:0]  sd_c;
	logic [CW-1:0]         sr_c;
	logic signed [KW-1:0]  sl_c;
	logic [CW-1:0]         diff;
	logic signed [lmc_pkg::PRODW-1:0] prod;
	lmc_pkg::scan_pkt_t    scan_c;
	logic [RW-1:0]         contrib;

	function automatic logic signed [SLW-1:0] lax(
		input logic signed [SLW-1:0] d,
		input logic [CW-1:0]         nd,
		input logic [CW-1:0]         rn
	);
		logic signed [KW-1:0] v;
		v = KW'(d) - $signed(KW'(nd)) + $signed(KW'(rn));
		if (v > KW'(lmc_pkg::SLACK_MAX)) begin
			return lmc_pkg::SLACK_MAX;
		end else if (v < KW'(lmc_pkg::SLACK_MIN)) begin
			return lmc_pkg::SLACK_MIN;
		end
		return SLW'(v);
	endfunction

	assign in_use  = 32'(cmd.n) > IDX;
	assign hit     = cmd.sel_v && (32'(cmd.idx) == IDX);
	assign dl_dec  = (dl_q != lmc_pkg::SLACK_MIN) ? dl_q - SLW'(1) : dl_q;
	assign run_inc = run_q + CW'(1);
	assign lax_rel = lax(dl_q, need_q, run_q);
	assign lax_hit = lax(dl_dec, need_q, run_inc);
	assign lax_oth = lax(dl_dec, need_q, run_q);

	assign rel_go = (cmd.op == lmc_pkg::CMD_RELEASE) && in_use && !act_q && !done_q
		&& (rel_q == cmd.tick);
	assign upd_go = (cmd.op == lmc_pkg::CMD_UPDATE) && in_use && act_q;
	assign fin_go = upd_go && hit && (run_inc >= need_q);

	assign miss = (rel_go && (lax_rel < 0)) || (fin_go && (lax_hit < 0));

	always_comb begin
		sd_c = act_q ? KW'(dl_q)
			: KW'(dl_q) + $signed(KW'(rel_q)) - $signed(KW'(cmd.tick));
		sd_c = sd_c - KW'(1);
		sr_c = run_q + CW'(hit);
		sl_c = sd_c - $signed(KW'(need_q)) + $signed(KW'(sr_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			slack_q <= lmc_pkg::SLACK_MAX;
			act_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (cmd.op)
				lmc_pkg::CMD_WRITE: begin
					if (hit) begin
						run_q   <= '0;
						slack_q <= lmc_pkg::SLACK_MAX;
						act_q   <= 1'b0;
						done_q  <= 1'b0;
					end
				end
				lmc_pkg::CMD_RELEASE: begin
					if (rel_go) begin
						act_q   <= 1'b1;
						slack_q <= lax_rel;
					end
				end
				lmc_pkg::CMD_UPDATE: begin
					if (upd_go) begin
						if (hit) begin
							run_q <= run_inc;
							if (fin_go) begin
								done_q  <= 1'b1;
								act_q   <= 1'b0;
								slack_q <= lmc_pkg::SLACK_MAX;
							end else begin
								slack_q <= lax_hit;
							end
						end else begin
							slack_q <= lax_oth;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == lmc_pkg::CMD_WRITE && hit) begin
			dl_q   <= SLW'(cmd.deadline);
			need_q <= CW'(cmd.needed);
			rel_q  <= cmd.release_tick;
		end else if (upd_go) begin
			dl_q <= dl_dec;
		end
		if (cmd.op == lmc_pkg::CMD_PREP) begin
			sd_q  <= sd_c;
			sl_q  <= sl_c;
			rem_q <= need_q - sr_c;
		end
	end

	always_comb begin
		scan_c = scan_i;
		diff   = need_q - run_q;
		prod   = $signed(lmc_pkg::PRODW'(diff)) * lmc_pkg::PRODW'(slack_q);
		if (in_use) begin
			if (done_q) begin
				scan_c.fin = scan_i.fin + lmc_pkg::CNTW'(1);
			end
			if (act_q) begin
				scan_c.act_cnt = scan_i.act_cnt + lmc_pkg::CNTW'(1);
			end
			if (act_q && (run_q != need_q)) begin
				if (!scan_i.pv || (prod < scan_i.pval)) begin
					scan_c.pv   = 1'b1;
					scan_c.pidx = lmc_pkg::IDXW'(IDX);
					scan_c.pval = prod;
					scan_c.prun = lmc_pkg::RUNW'(run_q);
				end
				if (!scan_i.sv || (slack_q < scan_i.sval)) begin
					scan_c.sv   = 1'b1;
					scan_c.sidx = lmc_pkg::IDXW'(IDX);
					scan_c.sval = slack_q;
					scan_c.srun = lmc_pkg::RUNW'(run_q);
				end
			end
			if (!done_q) begin
				if (sd_q > scan_i.dmax) begin
					scan_c.dmax = sd_q;
				end
				if (sl_q < 0) begin
					scan_c.fail = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_o <= scan_c;
	end

	always_comb begin
		contrib = '0;
		if (in_use && !done_q) begin
			if (sd_q <= $signed(dem_i.k)) begin
				contrib = RW'(rem_q);
			end else if (sl_q <= $signed(dem_i.k)) begin
				contrib = RW'(dem_i.k - KW'(sl_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dem_o <= '0;
		end else begin
			dem_o.v <= dem_i.v;
			dem_o.k <= dem_i.k;
			dem_o.r <= dem_i.r + contrib;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/llf_lmclf_task_scheduler.sv
// Top level of the least laxity first task scheduler: sequencer, counters and cell chain.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | s_tuser operation, s_tdata task fields
//  m_      | out | m_tvalid / m_tready   | m_tdata one result per item
//  cfg_    | in  | cfg_we                | cfg_wdata task_count
//
// A write item runs one count scan down the cell chain. A tick runs the release, the
// scans, the demand test when it is needed, the profile read and the update; the demand
// test sweeps k up to dmax, the largest next deadline (up to 131069), and
// pushes one k per cycle through the chain.
// Reset clears all task progress; one item is taken only from idle, and a finished
// result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module llf_lmclf_task_scheduler #(
	parameter int MAX_TASKS = lmc_pkg::MAX_TASKS_DEF,
	parameter int MAX_STEPS = lmc_pkg::MAX_STEPS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// task_index, step_index, deadline, exec_steps, release_tick, memory_value
	input  wire logic [lmc_pkg::IN_DATA_W-1:0]    s_tdata,
	// operation
	input  wire logic [1:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// ran_valid, ran_task, llf_switch, miss_event, finished_tasks, all_done,
	// memory_total, switch_total
	output logic [lmc_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [4:0]                       cfg_wdata
);

	localparam int DEPTH = MAX_TASKS * MAX_STEPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNTW  = lmc_pkg::CNTW;
	localparam int IDXW  = lmc_pkg::IDXW;
	localparam int RUNW  = lmc_pkg::RUNW;
	localparam int KW    = lmc_pkg::KW;
	localparam int RW    = lmc_pkg::RW;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_EXEC   = 11'b000_0000_0010,
		S_SCAN1  = 11'b000_0000_0100,
		S_PREP   = 11'b000_0000_1000,
		S_SCAN2  = 11'b000_0001_0000,
		S_DEM    = 11'b000_0010_0000,
		S_MEMRD  = 11'b000_0100_0000,
		S_MEMACC = 11'b000_1000_0000,
		S_UPD    = 11'b001_0000_0000,
		S_SCAN3  = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	lmc_pkg::op_t        op_q;
	logic [3:0]          ti_q;
	logic [5:0]          si_q;
	logic [15:0]         dl_in_q;
	logic [6:0]          ex_q;
	logic [15:0]         rel_in_q;
	logic [15:0]         mem_in_q;
	logic [CNTW-1:0]     cnt_q;
	logic [CNTW-1:0]     n_q;
	logic [15:0]         tick_q;
	logic [23:0]         msum_q;
	logic [15:0]         swc_q;
	logic [IDXW-1:0]     pick_q;
	logic [RUNW-1:0]     pick_run_q;
	logic [IDXW-1:0]     slk_idx_q;
	logic [RUNW-1:0]     slk_run_q;
	logic                ran_q;
	logic                sw_q;
	logic                miss_q;
	logic signed [KW-1:0] dmax_q;
	logic [KW-1:0]       k_q;
	logic                m_tvalid_q;
	logic [lmc_pkg::OUT_DATA_W-1:0] m_tdata_q;

	lmc_pkg::cell_cmd_t  cmd;
	lmc_pkg::scan_pkt_t  scan_w [MAX_TASKS+1];
	lmc_pkg::dem_pkt_t   dem_w  [MAX_TASKS+1];
	logic [MAX_TASKS-1:0] miss_w;
	lmc_pkg::scan_pkt_t  scan_end;
	lmc_pkg::dem_pkt_t   dem_end;

	logic [RUNW-1:0]     need_sat;
	logic                task_ok;
	logic                prof_ok;
	logic                scan_done;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [AW-1:0]       ram_raddr;
	logic [15:0]         ram_rdata;
	logic [24:0]         msum_add;
	logic                out_free;
	logic [CNTW-1:0]     cfg_sat;
	logic                dem_fail;
	logic                dem_last;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign scan_end  = scan_w[MAX_TASKS];
	assign dem_end   = dem_w[MAX_TASKS];
	assign scan_done = (cnt_q == CNTW'(MAX_TASKS));
	assign task_ok   = 32'(ti_q) < MAX_TASKS;
	assign prof_ok   = task_ok && (32'(si_q) < MAX_STEPS);
	assign out_free  = !m_tvalid_q || m_tready;
	assign dem_fail  = dem_end.v && (RW'(dem_end.k) < dem_end.r);
	assign dem_last  = dem_end.v && ($signed(dem_end.k) == dmax_q);

	always_comb begin
		if (ex_q == 7'd0) begin
			need_sat = RUNW'(1);
		end else if (32'(ex_q) > MAX_STEPS) begin
			need_sat = RUNW'(MAX_STEPS);
		end else begin
			need_sat = RUNW'(ex_q);
		end
		if (cfg_wdata == 5'd0) begin
			cfg_sat = CNTW'(1);
		end else if (32'(cfg_wdata) > MAX_TASKS) begin
			cfg_sat = CNTW'(MAX_TASKS);
		end else begin
			cfg_sat = CNTW'(cfg_wdata);
		end
	end

	always_comb begin
		cmd.op           = lmc_pkg::CMD_NONE;
		cmd.idx          = pick_q;
		cmd.sel_v        = 1'b0;
		cmd.needed       = need_sat;
		cmd.deadline     = dl_in_q;
		cmd.release_tick = rel_in_q;
		cmd.tick         = tick_q;
		cmd.n            = n_q;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == lmc_pkg::OP_TASK && task_ok) begin
					cmd.op    = lmc_pkg::CMD_WRITE;
					cmd.idx   = IDXW'(ti_q);
					cmd.sel_v = 1'b1;
				end else if (op_q == lmc_pkg::OP_TICK) begin
					cmd.op = lmc_pkg::CMD_RELEASE;
				end
			end
			S_PREP: begin
				cmd.op    = lmc_pkg::CMD_PREP;
				cmd.sel_v = 1'b1;
			end
			S_UPD: begin
				cmd.op    = lmc_pkg::CMD_UPDATE;
				cmd.sel_v = ran_q;
			end
			default: begin
			end
		endcase
	end

	assign scan_w[0]   = '0;
	assign dem_w[0].v  = (state_q == S_DEM) && ($signed(k_q) <= dmax_q);
	assign dem_w[0].k  = k_q;
	assign dem_w[0].r  = '0;

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		lmc_cell #(
			.IDX       (g),
			.MAX_STEPS (MAX_STEPS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.scan_i (scan_w[g]),
			.scan_o (scan_w[g+1]),
			.dem_i  (dem_w[g]),
			.dem_o  (dem_w[g+1]),
			.miss   (miss_w[g])
		);
	end

	assign ram_we    = (state_q == S_EXEC) && (op_q == lmc_pkg::OP_PROFILE) && prof_ok;
	assign ram_waddr = AW'(ti_q) * AW'(MAX_STEPS) + AW'(si_q);
	assign ram_raddr = AW'(pick_q) * AW'(MAX_STEPS) + AW'(pick_run_q);
	assign msum_add  = {1'b0, msum_q} + 25'(ram_rdata);

	lmc_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_profile (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mem_in_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q     <= lmc_pkg::op_t'(s_tuser);
			ti_q     <= s_tdata[3:0];
			si_q     <= s_tdata[9:4];
			dl_in_q  <= s_tdata[25:10];
			ex_q     <= s_tdata[32:26];
			rel_in_q <= s_tdata[48:33];
			mem_in_q <= s_tdata[64:49];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			n_q        <= CNTW'(1);
			tick_q     <= '0;
			msum_q     <= '0;
			swc_q      <= '0;
			pick_q     <= '0;
			pick_run_q <= '0;
			slk_idx_q  <= '0;
			slk_run_q  <= '0;
			ran_q      <= 1'b0;
			sw_q       <= 1'b0;
			miss_q     <= 1'b0;
			dmax_q     <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				n_q <= cfg_sat;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == S_SCAN1 || state_q == S_SCAN2 || state_q == S_SCAN3) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else begin
				cnt_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ran_q  <= 1'b0;
					sw_q   <= 1'b0;
					miss_q <= 1'b0;
					if (op_q == lmc_pkg::OP_TICK) begin
						miss_q  <= |miss_w;
						state_q <= S_SCAN1;
					end else begin
						state_q <= S_SCAN3;
					end
				end
				S_SCAN1: begin
					if (scan_done) begin
						pick_q     <= scan_end.pidx;
						pick_run_q <= scan_end.prun;
						slk_idx_q  <= scan_end.sidx;
						slk_run_q  <= scan_end.srun;
						if (scan_end.fin != n_q && scan_end.act_cnt != '0 && scan_end.pv) begin
							state_q <= (scan_end.act_cnt > CNTW'(1)) ? S_PREP : S_MEMRD;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_PREP: begin
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (scan_done) begin
						dmax_q <= scan_end.dmax;
						k_q    <= KW'(1);
						if (scan_end.fail) begin
							sw_q       <= 1'b1;
							swc_q      <= (swc_q == 16'hFFFF) ? swc_q : swc_q + 16'd1;
							pick_q     <= slk_idx_q;
							pick_run_q <= slk_run_q;
							state_q    <= S_MEMRD;
						end else if (scan_end.dmax > 0) begin
							state_q <= S_DEM;
						end else begin
							state_q <= S_MEMRD;
						end
					end
				end
				S_DEM: begin
					k_q <= k_q + KW'(1);
					if (dem_fail) begin
						sw_q       <= 1'b1;
						swc_q      <= (swc_q == 16'hFFFF) ? swc_q : swc_q + 16'd1;
						pick_q     <= slk_idx_q;
						pick_run_q <= slk_run_q;
						state_q    <= S_MEMRD;
					end else if (dem_last) begin
						state_q <= S_MEMRD;
					end
				end
				S_MEMRD: begin
					state_q <= S_MEMACC;
				end
				S_MEMACC: begin
					ran_q   <= 1'b1;
					msum_q  <= msum_add[24] ? 24'hFF_FFFF : msum_add[23:0];
					state_q <= S_UPD;
				end
				S_UPD: begin
					miss_q  <= miss_q | (|miss_w);
					tick_q  <= tick_q + 16'd1;
					state_q <= S_SCAN3;
				end
				S_SCAN3: begin
					if (scan_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, swc_q, msum_q,
							scan_end.fin == n_q, scan_end.fin[4:0], miss_q, sw_q,
							ran_q ? pick_q[3:0] : 4'd0, ran_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) msum_q >= $past(msum_q))
		else $error("memory total decreased");

	assert property (@(posedge clk) disable iff (!arst_n)
		(swc_q != $past(swc_q)) |-> sw_q)
		else $error("switch count moved without a switch");

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_DEM) |-> (dmax_q > 0))
		else $error("demand test running with no deadline span");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEMACC) |-> (32'(pick_q) < MAX_TASKS))
		else $error("picked task outside the table");

endmodule
`default_nettype wire

FILE: bench/llf_lmclf_task_scheduler_tb.sv
// Self-checking testbench for the least laxity first task scheduler.
`timescale 1ns / 1ps
module llf_lmclf_task_scheduler_tb;
	import lmc_pkg::*;

	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int NT = 16;
	localparam int NS = 64;
	localparam int DRAIN = 200;

	typedef struct {
		bit        ran;
		bit [3:0]  task_id;
		bit        sw;
		bit        miss;
		bit [4:0]  fin;
		bit        all_fin;
		bit [23:0] mem;
		bit [15:0] sw_tot;
	} sched_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [4:0] cfg_wdata = '0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int errors = 0;
	sched_res_t sched_q[$];

	// mirror of the scheduler state
	int tcount;
	int dl_left[NT], need[NT], rel_at[NT], run_cnt[NT], slk[NT];
	bit act[NT], done[NT], task_wr[NT];
	int prof[NT*NS];
	bit prof_wr[NT*NS];
	int tick_cnt, mem_sum, sw_cnt;

	llf_lmclf_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	function automatic int clamp18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return int'(v);
	endfunction

	function automatic int laxity(int i);
		return clamp18(longint'(dl_left[i]) - need[i] + run_cnt[i]);
	endfunction

	function automatic int least_task(bit by_product);
		int best;
		longint best_v, v;
		best = -1;
		best_v = 0;
		for (int i = 0; i < tcount; i++) begin
			if (!act[i] || run_cnt[i] == need[i])
				continue;
			v = by_product ? longint'(need[i] - run_cnt[i]) * slk[i] : longint'(slk[i]);
			if (best < 0 || v < best_v) begin
				best = i;
				best_v = v;
			end
		end
		return best;
	endfunction

	function automatic bit demand_fails(int sel);
		longint sd[NT], sl[NT], sr[NT];
		longint dmax, r;
		bit fail;
		dmax = 0;
		fail = 0;
		for (int i = 0; i < tcount; i++) begin
			if (done[i])
				continue;
			sd[i] = act[i] ? longint'(dl_left[i]) : longint'(dl_left[i]) + rel_at[i] - tick_cnt;
			sr[i] = run_cnt[i] + (i == sel);
			sd[i] -= 1;
			if (sd[i] > dmax)
				dmax = sd[i];
			sl[i] = sd[i] - need[i] + sr[i];
			if (sl[i] < 0)
				fail = 1;
		end
		for (longint k = 1; !fail && k <= dmax; k++) begin
			r = 0;
			for (int i = 0; i < tcount; i++) begin
				if (done[i])
					continue;
				if (sd[i] <= k)
					r += need[i] - sr[i];
				else if (sl[i] <= k)
					r += k - sl[i];
			end
			if (k - r < 0)
				fail = 1;
		end
		return fail;
	endfunction

	function automatic int finished_count();
		int f;
		f = 0;
		for (int i = 0; i < tcount; i++)
			f += done[i];
		return f;
	endfunction

	function automatic void sched_reset();
		tcount = 1;
		for (int i = 0; i < NT; i++) begin
			dl_left[i] = 0; need[i] = 0; rel_at[i] = 0; run_cnt[i] = 0;
			slk[i] = 131071; act[i] = 0; done[i] = 0; task_wr[i] = 0;
		end
		for (int i = 0; i < NT*NS; i++) begin
			prof[i] = 0;
			prof_wr[i] = 0;
		end
		tick_cnt = 0; mem_sum = 0; sw_cnt = 0;
	endfunction

	function automatic void predict_step(logic [1:0] op, int ti, int si, int dead, int ex,
			int rel, int mv);
		sched_res_t e;
		bit sw, miss;
		int pick, cnt, fin, c;
		sw = 0; miss = 0; pick = -1;
		if (op == OP_TASK) begin
			c = ex < 1 ? 1 : (ex > NS ? NS : ex);
			dl_left[ti] = dead; need[ti] = c; rel_at[ti] = rel; run_cnt[ti] = 0;
			slk[ti] = 131071; act[ti] = 0; done[ti] = 0; task_wr[ti] = 1;
		end else if (op == OP_PROFILE) begin
			prof[ti*NS+si] = mv;
			prof_wr[ti*NS+si] = 1;
		end else if (op == OP_TICK) begin
			for (int i = 0; i < tcount; i++)
				if (!act[i] && !done[i] && rel_at[i] == tick_cnt) begin
					act[i] = 1;
					slk[i] = laxity(i);
					if (slk[i] < 0)
						miss = 1;
				end
			fin = 0; cnt = 0;
			for (int i = 0; i < tcount; i++) begin
				fin += done[i];
				cnt += act[i];
			end
			if (fin != tcount && cnt > 0)
				pick = least_task(1);
			if (fin != tcount && cnt > 1 && pick >= 0 && demand_fails(pick)) begin
				sw = 1;
				if (sw_cnt < 65535)
					sw_cnt++;
				pick = least_task(0);
			end
			if (pick >= 0 && run_cnt[pick] < NS) begin
				mem_sum += prof[pick*NS + run_cnt[pick]];
				if (mem_sum > 24'hFFFFFF)
					mem_sum = 24'hFFFFFF;
			end
			for (int i = 0; i < tcount; i++) begin
				if (!act[i])
					continue;
				if (dl_left[i] > -131072)
					dl_left[i]--;
				if (i == pick) begin
					run_cnt[i]++;
					slk[i] = laxity(i);
					if (run_cnt[i] >= need[i]) begin
						done[i] = 1;
						act[i] = 0;
						if (slk[i] < 0)
							miss = 1;
						slk[i] = 131071;
					end
				end else begin
					slk[i] = laxity(i);
				end
			end
			tick_cnt = (tick_cnt + 1) & 16'hFFFF;
		end
		fin = finished_count();
		e.ran = pick >= 0;
		e.task_id = pick >= 0 ? pick[3:0] : 4'd0;
		e.sw = sw;
		e.miss = miss;
		e.fin = fin[4:0];
		e.all_fin = fin == tcount;
		e.mem = mem_sum[23:0];
		e.sw_tot = sw_cnt[15:0];
		sched_q.push_back(e);
	endfunction

	task automatic report(string field, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sched_res_t e;
		if (m_tvalid && m_tready) begin
			if (sched_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				e = sched_q.pop_front();
				report("ran_valid", e.ran, m_tdata[0]);
				report("ran_task", e.task_id, m_tdata[4:1]);
				report("llf_switch", e.sw, m_tdata[5]);
				report("miss_event", e.miss, m_tdata[6]);
				report("finished_tasks", e.fin, m_tdata[11:7]);
				report("all_done", e.all_fin, m_tdata[12]);
				report("memory_total", e.mem, m_tdata[36:13]);
				report("switch_total", e.sw_tot, m_tdata[52:37]);
			end
		end
	end

	task automatic send(logic [1:0] op, int ti, int si, int dead, int ex, int rel, int mv);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {7'd0, mv[15:0], rel[15:0], ex[6:0], dead[15:0], si[5:0], ti[3:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_step(op, ti, si, dead, ex, rel, mv);
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		while (sched_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_task_count(int v);
		wait_idle();
		cfg_we <= 1;
		cfg_wdata <= v[4:0];
		@(posedge clk);
		cfg_we <= 0;
		v = v & 31;
		tcount = v < 1 ? 1 : (v > NT ? NT : v);
		@(posedge clk);
	endtask

	task automatic write_task(int ti, int dead, int ex, int rel);
		send(OP_TASK, ti, $urandom_range(63), dead, ex, rel, $urandom_range(65535));
	endtask

	// fill in every entry and profile word a tick may read
	task automatic tick();
		for (int i = 0; i < tcount; i++) begin
			if (!task_wr[i])
				write_task(i, $urandom_range(60, 2), $urandom_range(4, 1), tick_cnt);
			for (int s = 0; s < need[i]; s++)
				if (!prof_wr[i*NS+s])
					send(OP_PROFILE, i, s, $urandom_range(65535), $urandom_range(127),
						$urandom_range(65535), $urandom_range(65535));
		end
		send(OP_TICK, $urandom_range(15), $urandom_range(63), $urandom_range(65535),
			$urandom_range(127), $urandom_range(65535), $urandom_range(65535));
	endtask

	task automatic run_until_done(int max_ticks);
		for (int t = 0; t < max_ticks && finished_count() != tcount; t++)
			tick();
	endtask

	task automatic test_basic_run();
		write_task(0, 1, 0, 0);
		run_until_done(3);
		tick();
	endtask

	task automatic test_field_extremes();
		set_task_count(0);
		write_task(0, 65535, 127, tick_cnt);
		for (int s = 0; s < NS; s++)
			send(OP_PROFILE, 0, s, 0, 0, 0, s[0] ? 65535 : 0);
		repeat (3) tick();
		write_task(0, 65535, 64, 65535);
		repeat (2) tick();
	endtask

	task automatic test_missed_release();
		set_task_count(2);
		write_task(0, 20, 3, tick_cnt);
		write_task(1, 20, 2, (tick_cnt + 65535) & 16'hFFFF);
		run_until_done(5);
		tick();
	endtask

	task automatic test_negative_laxity();
		set_task_count(1);
		write_task(0, 1, 5, tick_cnt);
		run_until_done(6);
	endtask

	task automatic test_unknown_op();
		send(OP_IDLE, 15, 63, 65535, 127, 65535, 65535);
		send(OP_IDLE, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_llf_switch();
		set_task_count(3);
		write_task(0, 4, 2, tick_cnt);
		write_task(1, 5, 3, tick_cnt);
		write_task(2, 9, 1, tick_cnt);
		run_until_done(12);
	endtask

	task automatic test_random(int items);
		int start_n, mode;
		int counts[6] = '{1, 16, 31, 0, 3, 17};
		start_n = 0;
		for (int ph = 0; start_n < items; ph++) begin
			mode = ph % 4;
			src_idle_pct = mode == 1 ? 85 : (mode == 3 ? 20 : 0);
			snk_stall_pct = mode == 2 ? 85 : (mode == 3 ? 20 : 0);
			set_task_count(ph < 6 ? counts[ph] : $urandom_range(16, 2));
			for (int i = 0; i < tcount; i++)
				write_task(i, $urandom_range(40, 1), $urandom_range(6, 1),
					(tick_cnt + $urandom_range(3)) & 16'hFFFF);
			start_n += tcount;
			for (int t = 0; t < 30 && finished_count() != tcount; t++) begin
				case ($urandom_range(9))
					0: send(OP_IDLE, $urandom_range(15), $urandom_range(63),
						$urandom_range(65535), $urandom_range(127), $urandom_range(65535),
						$urandom_range(65535));
					1: send(OP_PROFILE, $urandom_range(15), $urandom_range(63), 0, 0, 0,
						$urandom_range(65535));
					2: write_task($urandom_range(tcount - 1), $urandom_range(30, 1),
						$urandom_range(5, 1), (tick_cnt + $urandom_range(2)) & 16'hFFFF);
					default: tick();
				endcase
				start_n++;
			end
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;
	endtask

	task automatic test_memory_saturation();
		set_task_count(1);
		for (int s = 0; s < NS; s++)
			send(OP_PROFILE, 0, s, 0, 0, 0, 65535);
		for (int r = 0; r < 5; r++) begin
			write_task(0, 200, 64, tick_cnt);
			run_until_done(64);
		end
	endtask

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		sched_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_basic_run();
		test_unknown_op();
		test_field_extremes();
		test_missed_release();
		test_negative_laxity();
		test_llf_switch();
		test_random(300);
		test_memory_saturation();
		wait_idle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
